// ===== hdl/felpm_pkg.sv =====
// Shared types, constants and helpers for the flash event log pointer manager.
`timescale 1ns / 1ps

package felpm_pkg;

    localparam int DEF_CHUNK_BYTES      = 256;
    localparam int DEF_ERASE_PAGE_BYTES = 2048;
    localparam int DEF_MAX_READ_RECORDS = 16;

    localparam logic [7:0]  REC_MAGIC        = 8'hA5;
    localparam logic [31:0] REC_BYTES        = 32'd8;
    localparam logic [31:0] REGION_START_RST = 32'd134627328;
    localparam logic [31:0] REGION_END_RST   = 32'd134729728;

    // register index, taken from paddr[2]
    localparam logic REG_REGION_START = 1'b0;
    localparam logic REG_REGION_END   = 1'b1;

    typedef enum logic [2:0] {
        OP_OPEN   = 3'd0,
        OP_SEARCH = 3'd1,
        OP_TICK   = 3'd2,
        OP_SAVE   = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_CHECKING  = 2'd1,
        ST_READY     = 2'd2
    } t_log_state;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NOT_READY = 2'd1,
        ERR_FULL      = 2'd2
    } t_err;

    typedef struct packed {
        logic [31:0] region_start;
        logic [31:0] region_end;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] flash_record;
        logic [7:0]  event_type;
        logic [15:0] event_param;
        logic [31:0] timestamp;
        logic [19:0] first_index;
        logic [7:0]  read_count;
    } t_item;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] flash_address;
        logic [7:0]  byte_length;
        logic [63:0] record_out;
        logic [4:0]  records_returned;
        logic [19:0] log_count;
        t_log_state  log_state;
        t_err        error;
        logic        last;
    } t_result;

    // one processed item handed to the output buffer
    typedef struct packed {
        logic    load;
        logic    two;
        t_result res0;
        t_result res1;
    } t_load;

    function automatic logic rec_ok(input logic [63:0] rec);
        logic [7:0] x;
        x = rec[7:0] ^ rec[15:8] ^ rec[23:16] ^ rec[31:24]
          ^ rec[39:32] ^ rec[47:40] ^ rec[55:48] ^ rec[63:56];
        return x == REC_MAGIC;
    endfunction

endpackage

// ===== hdl/felpm_in_if.sv =====
// Input item channel: valid/ready handshake with the item fields.
`timescale 1ns / 1ps

interface felpm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] flash_record;
    logic [7:0]  event_type;
    logic [15:0] event_param;
    logic [31:0] timestamp;
    logic [19:0] first_index;
    logic [7:0]  read_count;

    modport source (
        output valid, op, flash_record, event_type, event_param, timestamp,
               first_index, read_count,
        input  ready
    );
    modport sink (
        input  valid, op, flash_record, event_type, event_param, timestamp,
               first_index, read_count,
        output ready
    );
endinterface

// ===== hdl/felpm_out_if.sv =====
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface felpm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] flash_address;
    logic [7:0]  byte_length;
    logic [63:0] record_out;
    logic [4:0]  records_returned;
    logic [19:0] log_count;
    logic [1:0]  log_state;
    logic [1:0]  error;
    logic        last;

    modport source (
        output valid, command, flash_address, byte_length, record_out,
               records_returned, log_count, log_state, error, last,
        input  ready
    );
    modport sink (
        input  valid, command, flash_address, byte_length, record_out,
               records_returned, log_count, log_state, error, last,
        output ready
    );
endinterface

// ===== hdl/felpm_cfg.sv =====
// APB register file holding the log region bounds.
`timescale 1ns / 1ps

module felpm_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output felpm_pkg::t_cfg     o_cfg
);

    felpm_pkg::t_cfg r_cfg;
    logic            wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;
    assign prdata = (paddr[2] == felpm_pkg::REG_REGION_END) ? r_cfg.region_end
                                                             : r_cfg.region_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_start <= felpm_pkg::REGION_START_RST;
            r_cfg.region_end   <= felpm_pkg::REGION_END_RST;
        end else if (wr_en) begin
            if (paddr[2] == felpm_pkg::REG_REGION_END) begin
                r_cfg.region_end <= pwdata;
            end else begin
                r_cfg.region_start <= pwdata;
            end
        end
    end

endmodule

// ===== hdl/felpm_core.sv =====
// Input register, pointer/search state and the per-item result logic.
`timescale 1ns / 1ps

module felpm_core #(
    parameter int CHUNK_BYTES      = felpm_pkg::DEF_CHUNK_BYTES,
    parameter int ERASE_PAGE_BYTES = felpm_pkg::DEF_ERASE_PAGE_BYTES,
    parameter int MAX_READ_RECORDS = felpm_pkg::DEF_MAX_READ_RECORDS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    felpm_in_if.sink        i_in,
    input  felpm_pkg::t_cfg i_cfg,
    input  logic            i_can_load,
    output felpm_pkg::t_load o_load
);

    // chunk and page sizes are powers of two
    localparam int          OFS_W     = $clog2(CHUNK_BYTES);
    localparam int          EP_W      = $clog2(ERASE_PAGE_BYTES);
    localparam logic [31:0] CHUNK_W   = 32'(CHUNK_BYTES);
    localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(CHUNK_BYTES - 8);
    localparam logic [OFS_W-1:0] OFS_STEP = OFS_W'(8);
    localparam logic [7:0]  MAX_RD    = 8'(MAX_READ_RECORDS);

    felpm_pkg::t_item      r_item;
    logic                  r_in_valid;
    logic [31:0]           r_wp,      n_wp;
    felpm_pkg::t_log_state r_state,   n_state;
    logic                  r_in_chunk, n_in_chunk;
    logic [OFS_W-1:0]      r_scan_ofs, n_ofs;

    logic                  in_take, fire;
    felpm_pkg::t_cmd       cmd;
    felpm_pkg::t_err       err;
    logic [31:0]           addr;
    logic [7:0]            len;
    logic [63:0]           rec;
    logic [4:0]            granted;
    logic                  erase;

    logic [31:0]           wp_span, n_wp_span;
    logic [28:0]           num, avail, first_ext;
    logic [7:0]            rd_clamp, rd_cnt;
    logic                  rd_none, full, rec_good;
    logic [7:0]            ck;
    logic [63:0]           save_rec;

    assign fire       = r_in_valid && i_can_load;
    assign i_in.ready = !r_in_valid || fire;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.op           <= i_in.op;
            r_item.flash_record <= i_in.flash_record;
            r_item.event_type   <= i_in.event_type;
            r_item.event_param  <= i_in.event_param;
            r_item.timestamp    <= i_in.timestamp;
            r_item.first_index  <= i_in.first_index;
            r_item.read_count   <= i_in.read_count;
        end
    end

    // shared terms
    assign rec_good  = felpm_pkg::rec_ok(r_item.flash_record);
    assign wp_span   = r_wp - i_cfg.region_start;
    assign num       = wp_span[31:3];
    assign first_ext = {9'd0, r_item.first_index};
    assign avail     = num - first_ext;
    assign rd_clamp  = (r_item.read_count > MAX_RD) ? MAX_RD : r_item.read_count;
    assign rd_none   = (first_ext >= num) || (rd_clamp == 8'd0);
    assign rd_cnt    = (avail <= {21'd0, rd_clamp}) ? avail[7:0] : rd_clamp;
    assign full      = (r_wp >= i_cfg.region_end)
                    || ((i_cfg.region_end - r_wp) < felpm_pkg::REC_BYTES);
    assign ck        = felpm_pkg::REC_MAGIC ^ r_item.event_type
                     ^ r_item.timestamp[7:0] ^ r_item.timestamp[15:8]
                     ^ r_item.timestamp[23:16] ^ r_item.timestamp[31:24]
                     ^ r_item.event_param[7:0] ^ r_item.event_param[15:8];
    assign save_rec  = {ck, r_item.event_param, r_item.timestamp, r_item.event_type};

    always_comb begin
        n_wp       = r_wp;
        n_state    = r_state;
        n_in_chunk = r_in_chunk;
        n_ofs      = r_scan_ofs;
        cmd        = felpm_pkg::CMD_NONE;
        err        = felpm_pkg::ERR_NONE;
        addr       = '0;
        len        = '0;
        rec        = '0;
        granted    = '0;
        erase      = 1'b0;
        unique case (felpm_pkg::t_op'(r_item.op))
            felpm_pkg::OP_OPEN: begin
                n_state    = felpm_pkg::ST_SEARCHING;
                n_in_chunk = 1'b0;
                n_ofs      = '0;
                n_wp       = i_cfg.region_end - CHUNK_W;
                cmd        = felpm_pkg::CMD_READ;
                addr       = i_cfg.region_end - CHUNK_W;
                len        = 8'd8;
            end
            felpm_pkg::OP_SEARCH: begin
                if (r_state != felpm_pkg::ST_SEARCHING) begin
                    // records arriving outside the search are dropped
                end else if (!r_in_chunk) begin
                    if (rec_good) begin
                        n_in_chunk = 1'b1;
                        n_ofs      = OFS_LAST;
                        cmd        = felpm_pkg::CMD_READ;
                        addr       = r_wp + 32'(OFS_LAST);
                        len        = 8'd8;
                    end else if (r_wp <= i_cfg.region_start) begin
                        n_wp    = i_cfg.region_start;
                        n_state = felpm_pkg::ST_CHECKING;
                    end else begin
                        n_wp = r_wp - CHUNK_W;
                        cmd  = felpm_pkg::CMD_READ;
                        addr = r_wp - CHUNK_W;
                        len  = 8'd8;
                    end
                end else begin
                    if (rec_good) begin
                        n_wp       = r_wp + 32'(r_scan_ofs) + felpm_pkg::REC_BYTES;
                        n_in_chunk = 1'b0;
                        n_ofs      = '0;
                        n_state    = felpm_pkg::ST_CHECKING;
                    end else if (r_scan_ofs < OFS_STEP) begin
                        // whole chunk past its header is blank
                        n_in_chunk = 1'b0;
                        n_ofs      = '0;
                        n_state    = felpm_pkg::ST_CHECKING;
                    end else begin
                        n_ofs = r_scan_ofs - OFS_STEP;
                        cmd   = felpm_pkg::CMD_READ;
                        addr  = r_wp + 32'(r_scan_ofs - OFS_STEP);
                        len   = 8'd8;
                    end
                end
            end
            felpm_pkg::OP_TICK: begin
                if (r_state == felpm_pkg::ST_CHECKING) begin
                    n_state = felpm_pkg::ST_READY;
                end
            end
            felpm_pkg::OP_SAVE: begin
                if (r_state != felpm_pkg::ST_READY) begin
                    err = felpm_pkg::ERR_NOT_READY;
                end else if (full) begin
                    err = felpm_pkg::ERR_FULL;
                end else begin
                    erase = (r_wp[EP_W-1:0] == '0);
                    n_wp  = r_wp + felpm_pkg::REC_BYTES;
                    cmd   = felpm_pkg::CMD_WRITE;
                    addr  = r_wp;
                    len   = 8'd8;
                    rec   = save_rec;
                end
            end
            felpm_pkg::OP_READ: begin
                if (!rd_none) begin
                    cmd     = felpm_pkg::CMD_READ;
                    addr    = i_cfg.region_start + {9'd0, r_item.first_index, 3'd0};
                    len     = {rd_cnt[4:0], 3'd0};
                    granted = rd_cnt[4:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign n_wp_span = n_wp - i_cfg.region_start;

    always_comb begin
        o_load.load = fire;
        o_load.two  = erase;

        o_load.res1.command          = cmd;
        o_load.res1.flash_address    = addr;
        o_load.res1.byte_length      = len;
        o_load.res1.record_out       = rec;
        o_load.res1.records_returned = granted;
        o_load.res1.log_count        = n_wp_span[22:3];
        o_load.res1.log_state        = n_state;
        o_load.res1.error            = err;
        o_load.res1.last             = 1'b1;

        if (erase) begin
            // page erase goes out first, with the count before the write
            o_load.res0.command          = felpm_pkg::CMD_ERASE;
            o_load.res0.flash_address    = r_wp;
            o_load.res0.byte_length      = 8'd8;
            o_load.res0.record_out       = '0;
            o_load.res0.records_returned = '0;
            o_load.res0.log_count        = wp_span[22:3];
            o_load.res0.log_state        = r_state;
            o_load.res0.error            = felpm_pkg::ERR_NONE;
            o_load.res0.last             = 1'b0;
        end else begin
            o_load.res0 = o_load.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= felpm_pkg::REGION_END_RST - CHUNK_W;
            r_state    <= felpm_pkg::ST_SEARCHING;
            r_in_chunk <= 1'b0;
            r_scan_ofs <= '0;
        end else if (fire) begin
            r_wp       <= n_wp;
            r_state    <= n_state;
            r_in_chunk <= n_in_chunk;
            r_scan_ofs <= n_ofs;
        end
    end

`ifndef SYNTH
    a_chunk_only_searching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_chunk |-> (r_state == felpm_pkg::ST_SEARCHING))
        else $error("chunk scan active outside search");
    a_ofs_zero_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_chunk |-> (r_scan_ofs == '0))
        else $error("scan offset left nonzero in header phase");
    a_ofs_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_ofs[2:0] == 3'd0)
        else $error("scan offset not record aligned");
`endif

endmodule

// ===== hdl/felpm_obuf.sv =====
// Two-entry result buffer that drives the result channel.
`timescale 1ns / 1ps

module felpm_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  felpm_pkg::t_load i_load,
    output logic             o_can_load,
    felpm_out_if.source      o_out
);

    logic [1:0]         r_cnt;
    felpm_pkg::t_result r_slot0;
    felpm_pkg::t_result r_slot1;
    logic               take;

    assign o_out.valid = (r_cnt != 2'd0);
    assign take        = o_out.valid && o_out.ready;
    // refill only once everything queued is gone by this edge
    assign o_can_load  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);

    assign o_out.command          = r_slot0.command;
    assign o_out.flash_address    = r_slot0.flash_address;
    assign o_out.byte_length      = r_slot0.byte_length;
    assign o_out.record_out       = r_slot0.record_out;
    assign o_out.records_returned = r_slot0.records_returned;
    assign o_out.log_count        = r_slot0.log_count;
    assign o_out.log_state        = r_slot0.log_state;
    assign o_out.error            = r_slot0.error;
    assign o_out.last             = r_slot0.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load.load) begin
            r_cnt <= i_load.two ? 2'd2 : 2'd1;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_slot0 <= i_load.res0;
            r_slot1 <= i_load.res1;
        end else if (take) begin
            r_slot0 <= r_slot1;
        end
    end

`ifndef SYNTH
    a_load_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |-> ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && take)))
        else $error("result load would overwrite a pending transfer");
    a_head_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_slot0.last)
        else $error("first of two results marked last");
    a_second_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == 2'd2) && take) |=> (r_slot0.last && (r_cnt == 2'd1)))
        else $error("second result lost or not marked last");
`endif

endmodule

// ===== hdl/flash_event_log_pointer_manager.sv =====
// Flash event log pointer manager top level.
// Path: an accepted item is held in the input register, then its results go to the
// result buffer. Throughput: one item per cycle while the result channel is ready;
// a page-erasing save holds the channel for two transfers, set by the result buffer.
// Reset: synchronous active low; the region bounds return to their defaults and the
// write pointer to region end minus one chunk, search restarts; no clearing pass.
`timescale 1ns / 1ps

module flash_event_log_pointer_manager #(
    parameter int CHUNK_BYTES      = felpm_pkg::DEF_CHUNK_BYTES,
    parameter int ERASE_PAGE_BYTES = felpm_pkg::DEF_ERASE_PAGE_BYTES,
    parameter int MAX_READ_RECORDS = felpm_pkg::DEF_MAX_READ_RECORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    felpm_in_if.sink    i_in,
    felpm_out_if.source o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    felpm_pkg::t_cfg  cfg;
    felpm_pkg::t_load load;
    logic             can_load;

    felpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    felpm_core #(
        .CHUNK_BYTES      (CHUNK_BYTES),
        .ERASE_PAGE_BYTES (ERASE_PAGE_BYTES),
        .MAX_READ_RECORDS (MAX_READ_RECORDS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_can_load (can_load),
        .o_load     (load)
    );

    felpm_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule
